/* hw/rtl/serial_stamped_double_ended_queue_assert.svh */
// Assertion macros shared by the serial-stamped queue RTL.
// Plain text only; included by the modules that carry checks.
`ifndef SERIAL_STAMPED_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define SERIAL_STAMPED_DOUBLE_ENDED_QUEUE_ASSERT_SVH

// expr holds at every clock edge outside reset
`define SSDQ_ASSERT_ALWAYS(name, clk, rst, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// cons holds in the same cycle as ante
`define SSDQ_ASSERT_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// cons holds in the cycle after ante
`define SSDQ_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/ssdq_pkg.sv */
// Types and codes for the serial-stamped double-ended queue.
// No dependencies; used by the top level by scoped names.
package ssdq_pkg;

   localparam int MODE_W   = 3;
   localparam int STATUS_W = 2;
   localparam int SERIAL_W = 16;
   localparam int COUNT_W  = 8;
   localparam int DATA_W   = 32;
   localparam int OCC_W    = 4;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_TAIL = 3'd0,
      MODE_POP_HEAD  = 3'd1,
      MODE_POP_TAIL  = 3'd2,
      MODE_PEEK_HEAD = 3'd3,
      MODE_PEEK_TAIL = 3'd4,
      MODE_BUMP_HEAD = 3'd5,
      MODE_STATUS    = 3'd6
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   localparam logic [COUNT_W-1:0] COUNT_SAT = 8'hFF;
   localparam logic [SERIAL_W-1:0] SERIAL_RESET = 16'd1;
   localparam logic [SERIAL_W-1:0] SERIAL_WRAP  = 16'd1;

endpackage

/* hw/rtl/ssdq_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies; holds the entry stores of the queue.
module ssdq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/serial_stamped_double_ended_queue.sv */
// Top level of the serial-stamped double-ended queue: control FSM, pointers, result register.
// Depends on ssdq_pkg, ssdq_ram and serial_stamped_double_ended_queue_assert.svh.
//
//  channel | direction | handshake          | beat contents
//  req_    | in        | req_valid/req_stall | mode, payload, initial_count
//  rsp_    | out       | rsp_valid/rsp_stall | status, entry fields, occupancy, next_serial
//  csr_    | in        | csr_wr_en           | start serial (loads the serial counter)
//
// Each operation first reads the entry RAMs (registered read port), then executes and
// writes back pointers, counter and RAMs.
// A new request is taken as soon as the previous one has executed; the result register
// lets one result wait for rsp_stall while the next request reads the RAMs.
// Execute holds while the result register is full and stalled.
// Synchronous reset clears pointers, occupancy and FSM; no RAM clearing pass is needed.
module serial_stamped_double_ended_queue #(
   parameter int SLOTS        = 16,
   parameter int PAYLOAD_BITS = 32,
   parameter int SERIAL_MAX   = 59999
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [31:0] req_payload,
   input  logic [7:0]  req_initial_count,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_entry_payload,
   output logic [15:0] rsp_entry_serial,
   output logic [7:0]  rsp_entry_count,
   output logic [3:0]  rsp_occupancy,
   output logic [15:0] rsp_next_serial,

   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int PTR_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS);
   localparam int PW    = (PAYLOAD_BITS < ssdq_pkg::DATA_W) ? PAYLOAD_BITS : ssdq_pkg::DATA_W;
   localparam int SW    = ssdq_pkg::SERIAL_W;
   localparam int CW    = ssdq_pkg::COUNT_W;

   typedef enum logic {ST_IDLE, ST_EXEC} state_type;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(SLOTS-1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_W'(SLOTS-1) : p - 1'b1;
   endfunction

   state_type state_ff, state_in;
   logic [2:0]       op_mode_ff, op_mode_in;
   logic [PW-1:0]    op_payload_ff, op_payload_in;
   logic [CW-1:0]    op_count_ff, op_count_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [SW-1:0]    serial_ff, serial_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [31:0]      rsp_payload_ff, rsp_payload_in;
   logic [SW-1:0]    rsp_serial_ff, rsp_serial_in;
   logic [CW-1:0]    rsp_count_ff, rsp_count_in;
   logic [3:0]       rsp_occ_ff, rsp_occ_in;
   logic [SW-1:0]    rsp_next_ff, rsp_next_in;

   logic             req_take;
   logic             exec_go;
   logic             full;
   logic             empty;
   logic [PTR_W-1:0] next_head;
   logic [PTR_W-1:0] next_tail;
   logic [PTR_W-1:0] rd_addr;

   logic             data_we;
   logic [SW+PW-1:0] data_wdata;
   logic [SW+PW-1:0] data_rdata;
   logic             count_we;
   logic [PTR_W-1:0] count_waddr;
   logic [CW-1:0]    count_wdata;
   logic [CW-1:0]    count_rdata;

   logic [PW+31:0]    payload_ext;
   logic [CNT_W+3:0]  total_ext;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign exec_go   = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   assign next_head = ring_next(head_ff);
   assign next_tail = ring_next(tail_ff);
   assign full      = (next_tail == head_ff);
   assign empty     = (total_ff == '0);

   // peek tail reads the newest slot, everything else the oldest
   assign rd_addr = (req_mode == ssdq_pkg::MODE_PEEK_TAIL) ? tail_ff : next_head;

   assign data_wdata  = {serial_ff, op_payload_ff};
   assign payload_ext = {32'b0, data_rdata[PW-1:0]};
   assign total_ext   = {4'b0, total_in};

   ssdq_ram #(.WIDTH(SW + PW), .DEPTH(SLOTS)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (next_tail),
      .wr_data (data_wdata),
      .rd_en   (req_take),
      .rd_addr (rd_addr),
      .rd_data (data_rdata)
   );

   ssdq_ram #(.WIDTH(CW), .DEPTH(SLOTS)) u_count_ram (
      .clock   (clock),
      .wr_en   (count_we),
      .wr_addr (count_waddr),
      .wr_data (count_wdata),
      .rd_en   (req_take),
      .rd_addr (rd_addr),
      .rd_data (count_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      op_mode_in    = op_mode_ff;
      op_payload_in = op_payload_ff;
      op_count_in   = op_count_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      total_in      = total_ff;
      serial_in     = serial_ff;

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_serial_in  = rsp_serial_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_occ_in     = rsp_occ_ff;
      rsp_next_in    = rsp_next_ff;

      data_we     = 1'b0;
      count_we    = 1'b0;
      count_waddr = next_tail;
      count_wdata = op_count_ff;

      if (req_take) begin
         state_in      = ST_EXEC;
         op_mode_in    = req_mode;
         op_payload_in = req_payload[PW-1:0];
         op_count_in   = req_initial_count;
      end

      if (exec_go) begin
         state_in       = ST_IDLE;
         rsp_valid_in   = 1'b1;
         rsp_status_in  = ssdq_pkg::STATUS_DONE;
         rsp_payload_in = '0;
         rsp_serial_in  = '0;
         rsp_count_in   = '0;
         unique case (op_mode_ff)
            ssdq_pkg::MODE_PUSH_TAIL: begin
               if (full) begin
                  rsp_status_in = ssdq_pkg::STATUS_FULL;
               end else begin
                  tail_in       = next_tail;
                  total_in      = total_ff + 1'b1;
                  data_we       = 1'b1;
                  count_we      = 1'b1;
                  rsp_serial_in = serial_ff;
                  serial_in     = (serial_ff >= SW'(SERIAL_MAX)) ? ssdq_pkg::SERIAL_WRAP
                                                               : serial_ff + 1'b1;
               end
            end
            ssdq_pkg::MODE_POP_HEAD: begin
               if (empty) begin
                  rsp_status_in = ssdq_pkg::STATUS_EMPTY;
               end else begin
                  head_in  = next_head;
                  total_in = total_ff - 1'b1;
               end
            end
            ssdq_pkg::MODE_POP_TAIL: begin
               if (empty) begin
                  rsp_status_in = ssdq_pkg::STATUS_EMPTY;
               end else begin
                  tail_in  = ring_prev(tail_ff);
                  total_in = total_ff - 1'b1;
               end
            end
            ssdq_pkg::MODE_PEEK_HEAD, ssdq_pkg::MODE_PEEK_TAIL: begin
               if (empty) begin
                  rsp_status_in = ssdq_pkg::STATUS_EMPTY;
               end else begin
                  rsp_payload_in = payload_ext[31:0];
                  rsp_serial_in  = data_rdata[SW+PW-1:PW];
                  rsp_count_in   = count_rdata;
               end
            end
            ssdq_pkg::MODE_BUMP_HEAD: begin
               if (empty) begin
                  rsp_status_in = ssdq_pkg::STATUS_EMPTY;
               end else begin
                  count_we    = 1'b1;
                  count_waddr = next_head;
                  count_wdata = (count_rdata == ssdq_pkg::COUNT_SAT) ? ssdq_pkg::COUNT_SAT
                                                                     : count_rdata + 1'b1;
               end
            end
            default: begin
               // status query and unused code: report only
            end
         endcase
         rsp_occ_in  = total_ext[3:0];
         rsp_next_in = serial_in;
      end

      if (csr_wr_en) begin
         serial_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         total_ff     <= '0;
         serial_ff    <= ssdq_pkg::SERIAL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         total_ff     <= total_in;
         serial_ff    <= serial_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_mode_ff     <= op_mode_in;
      op_payload_ff  <= op_payload_in;
      op_count_ff    <= op_count_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_serial_ff  <= rsp_serial_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_occ_ff     <= rsp_occ_in;
      rsp_next_ff    <= rsp_next_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_payload = rsp_payload_ff;
   assign rsp_entry_serial  = rsp_serial_ff;
   assign rsp_entry_count   = rsp_count_ff;
   assign rsp_occupancy     = rsp_occ_ff;
   assign rsp_next_serial   = rsp_next_ff;

`include "serial_stamped_double_ended_queue_assert.svh"

   `SSDQ_ASSERT_ALWAYS(a_total_bound, clock, reset, total_ff <= CNT_W'(SLOTS-1), "occupancy above capacity")
   `SSDQ_ASSERT_IMPLY(a_empty_ptrs, clock, reset, total_ff == '0, head_ff == tail_ff, "empty queue with pointers apart")
   `SSDQ_ASSERT_ALWAYS(a_no_rw_overlap, clock, reset, !(req_take && (data_we || count_we)), "RAM read issued during write-back")
   `SSDQ_ASSERT_NEXT(a_push_serial, clock, reset, exec_go && (op_mode_ff == ssdq_pkg::MODE_PUSH_TAIL) && !full && !csr_wr_en, serial_ff != '0, "serial counter advanced to zero")

endmodule
